// ===== rtl/assert_macros.svh =====
// assertion helper macros for the gripper sequencer checkers
// no dependencies; included by files that hold concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/gcsh_pkg.sv =====
// shared types and codes for the gripper clamp and stall homing block
// no dependencies; used by every module of the block but the queue
package gcsh_pkg;

	// command classes handed from front to back
	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_OPEN  = 3'd1,
		OP_CLOSE = 3'd2,
		OP_HOME  = 3'd3,
		OP_STOP  = 3'd4,
		OP_RESET = 3'd5,
		OP_NONE  = 3'd6
	} op_t;

	localparam int OP_BITS = 3;

	// highest valid request code
	localparam logic [2:0] REQ_LAST = 3'd5;

	// configuration register indexes
	localparam logic [2:0] CFG_OPEN_TRQ    = 3'd0;
	localparam logic [2:0] CFG_CLOSE_TRQ   = 3'd1;
	localparam logic [2:0] CFG_RAMP_INIT   = 3'd2;
	localparam logic [2:0] CFG_MAX_DAC     = 3'd3;
	localparam logic [2:0] CFG_DAC_STEP    = 3'd4;
	localparam logic [2:0] CFG_STILL_THR   = 3'd5;
	localparam logic [2:0] CFG_STILL_NEED  = 3'd6;
	localparam logic [2:0] CFG_SETTLE      = 3'd7;

	// clamp states
	localparam logic [2:0] CLAMP_UNKNOWN = 3'd0;
	localparam logic [2:0] CLAMP_OPENING = 3'd1;
	localparam logic [2:0] CLAMP_OPEN    = 3'd2;
	localparam logic [2:0] CLAMP_CLOSING = 3'd3;
	localparam logic [2:0] CLAMP_CLOSED  = 3'd4;

	// mechanism states
	localparam logic [1:0] MECH_READY   = 2'd0;
	localparam logic [1:0] MECH_MOVING  = 2'd1;
	localparam logic [1:0] MECH_HOLDING = 2'd2;
	localparam logic [1:0] MECH_HOMING  = 2'd3;

	// drive modes
	localparam logic [1:0] MODE_POS     = 2'd0;
	localparam logic [1:0] MODE_TORQUE  = 2'd1;
	localparam logic [1:0] MODE_STOPPED = 2'd2;

	// configuration register file contents
	typedef struct packed {
		logic signed [15:0] open_trq;
		logic signed [15:0] close_trq;
		logic signed [15:0] ramp_init;
		logic signed [15:0] max_dac;
		logic [14:0]        dac_step;
		logic [15:0]        still_threshold;
		logic [7:0]         still_needed;
		logic [15:0]        settle_ticks;
	} cfg_t;

endpackage

// ===== rtl/gcsh_req_if.sv =====
// request channel: valid/ready handshake carrying one event beat
// no dependencies
interface gcsh_req_if #(
	parameter int POS_BITS = 32
) ();
	logic                       valid;
	logic                       ready;
	logic [2:0]                 req_type;
	logic signed [POS_BITS-1:0] raw_position;
	logic signed [15:0]         close_torque;

	modport source (output valid, req_type, raw_position, close_torque, input ready);
	modport sink   (input valid, req_type, raw_position, close_torque, output ready);
endinterface

// ===== rtl/gcsh_rsp_if.sv =====
// result channel: valid/ready handshake carrying one status beat
// no dependencies
interface gcsh_rsp_if #(
	parameter int DAC_BITS = 16,
	parameter int POS_BITS = 32
) ();
	logic                       valid;
	logic                       ready;
	logic                       accepted;
	logic [2:0]                 clamp_state;
	logic [1:0]                 mech_state;
	logic [1:0]                 drive_mode;
	logic signed [DAC_BITS-1:0] dac_out;
	logic signed [POS_BITS-1:0] target_pos;
	logic signed [POS_BITS-1:0] rel_position;
	logic                       homed_now;

	modport source (output valid, accepted, clamp_state, mech_state, drive_mode, dac_out,
		target_pos, rel_position, homed_now, input ready);
	modport sink   (input valid, accepted, clamp_state, mech_state, drive_mode, dac_out,
		target_pos, rel_position, homed_now, output ready);
endinterface

// ===== rtl/gcsh_front.sv =====
// front end: configuration registers, request intake and command classification
// depends on gcsh_pkg and gcsh_req_if
module gcsh_front #(
	parameter int DAC_BITS = 16,
	parameter int POS_BITS = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	gcsh_req_if.sink                                req,
	input  logic                                    cfg_we,
	input  logic [2:0]                              cfg_index,
	input  logic [15:0]                             cfg_wdata,
	output gcsh_pkg::cfg_t                          cfg,
	output logic                                    push_valid,
	input  logic                                    push_ready,
	output logic [gcsh_pkg::OP_BITS+POS_BITS+DAC_BITS-1:0] push_data
);
	import gcsh_pkg::*;

	localparam int DAC_HI = (DAC_BITS >= 16) ? 32767 : (2 ** (DAC_BITS - 1)) - 1;
	localparam int DAC_LO = -DAC_HI - 1;

	cfg_t                       cfg_q;
	op_t                        op;
	logic signed [15:0]         cmd16;
	logic signed [DAC_BITS-1:0] cmd_dac;

	// clamp a 16-bit torque into the dac range
	function automatic logic signed [15:0] sat16(input logic signed [15:0] v);
		logic signed [15:0] r;
		r = v;
		if (DAC_BITS < 16) begin
			if (v > DAC_HI) begin
				r = 16'(DAC_HI);
			end else if (v < DAC_LO) begin
				r = 16'(DAC_LO);
			end
		end
		return r;
	endfunction

	// configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_trq        <= -16'sd100;
			cfg_q.close_trq       <= 16'sd100;
			cfg_q.ramp_init       <= 16'sd10;
			cfg_q.max_dac         <= 16'sd80;
			cfg_q.dac_step        <= 15'd10;
			cfg_q.still_threshold <= 16'd1;
			cfg_q.still_needed    <= 8'd5;
			cfg_q.settle_ticks    <= 16'd5;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OPEN_TRQ:   cfg_q.open_trq        <= sat16(cfg_wdata);
				CFG_CLOSE_TRQ:  cfg_q.close_trq       <= sat16(cfg_wdata);
				CFG_RAMP_INIT:  cfg_q.ramp_init       <= sat16(cfg_wdata);
				CFG_MAX_DAC:    cfg_q.max_dac         <= sat16(cfg_wdata);
				CFG_DAC_STEP:   cfg_q.dac_step        <= cfg_wdata[14:0];
				CFG_STILL_THR:  cfg_q.still_threshold <= cfg_wdata;
				CFG_STILL_NEED: cfg_q.still_needed    <= cfg_wdata[7:0];
				CFG_SETTLE:     cfg_q.settle_ticks    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// classify the request
	always_comb begin
		op = (req.req_type <= REQ_LAST) ? op_t'(req.req_type) : OP_NONE;
	end

	// pick the torque a command would apply
	always_comb begin
		unique case (op)
			OP_OPEN:  cmd16 = cfg_q.open_trq;
			OP_CLOSE: cmd16 = (req.close_torque > 16'sd0) ? sat16(req.close_torque)
			                                              : cfg_q.close_trq;
			OP_HOME:  cmd16 = cfg_q.ramp_init;
			default:  cmd16 = 16'sd0;
		endcase
		cmd_dac = DAC_BITS'(cmd16);
	end

	assign push_valid = req.valid;
	assign req.ready  = push_ready;
	assign push_data  = {op, req.raw_position, cmd_dac};

endmodule

// ===== rtl/gcsh_queue.sv =====
// two-entry command queue between front and back
// depends on nothing but its width parameter
module gcsh_queue #(
	parameter int WIDTH = 51
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	localparam int DEPTH = 2;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= in_data;
		end
	end

endmodule

// ===== rtl/gcsh_back.sv =====
// back end: sequencer state, homing ramp, settle counter and result register
// depends on gcsh_pkg and gcsh_rsp_if
module gcsh_back #(
	parameter int DAC_BITS = 16,
	parameter int POS_BITS = 32
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  gcsh_pkg::cfg_t                                 cfg,
	input  logic                                           pop_valid,
	output logic                                           pop_ready,
	input  logic [gcsh_pkg::OP_BITS+POS_BITS+DAC_BITS-1:0] pop_data,
	gcsh_rsp_if.source                                     rsp
);
	import gcsh_pkg::*;

	localparam int SW = ((DAC_BITS > 15) ? DAC_BITS : 15) + 2;
	localparam int PW = POS_BITS + 1;
	localparam logic signed [DAC_BITS-1:0] DAC_MAXV = {1'b0, {(DAC_BITS-1){1'b1}}};
	localparam logic signed [DAC_BITS-1:0] DAC_MINV = {1'b1, {(DAC_BITS-1){1'b0}}};

	// sequencer state
	logic [2:0]                 clamp_q, clamp_d;
	logic [1:0]                 mech_q, mech_d;
	logic [1:0]                 mode_q, mode_d;
	logic                       homing_q, homing_d;
	logic signed [POS_BITS-1:0] last_q, last_d;
	logic [7:0]                 still_q, still_d;
	logic signed [DAC_BITS-1:0] dac_q, dac_d;
	logic [15:0]                settle_q, settle_d;
	logic signed [POS_BITS-1:0] zero_q, zero_d;
	logic signed [POS_BITS-1:0] target_q, target_d;

	// result register
	logic                       ovalid_q;
	logic                       acc_q;
	logic                       homed_q;
	logic signed [POS_BITS-1:0] rel_q;

	// item fields and datapath
	op_t                        op;
	logic signed [POS_BITS-1:0] raw;
	logic signed [DAC_BITS-1:0] cmd_dac;
	logic signed [PW-1:0]       diff;
	logic [PW-1:0]              delta_abs;
	logic                       is_still;
	logic [7:0]                 still_inc;
	logic signed [SW-1:0]       ramp_sum;
	logic signed [DAC_BITS-1:0] ramp_sat;
	logic                       ramp_fits;
	logic [15:0]                settle_start;
	logic                       acc;
	logic                       homed;
	logic signed [POS_BITS-1:0] rel;
	logic                       pop;

	assign op      = op_t'(pop_data[OP_BITS+POS_BITS+DAC_BITS-1 -: OP_BITS]);
	assign raw     = pop_data[POS_BITS+DAC_BITS-1 -: POS_BITS];
	assign cmd_dac = pop_data[DAC_BITS-1:0];

	// take the next beat whenever the result slot frees up
	assign pop_ready = !ovalid_q || rsp.ready;
	assign pop       = pop_valid && pop_ready;

	// stall detect on position change
	always_comb begin
		diff      = PW'(raw) - PW'(last_q);
		delta_abs = diff[PW-1] ? PW'(-diff) : PW'(diff);
		is_still  = delta_abs < PW'(cfg.still_threshold);
		still_inc = (still_q == 8'hFF) ? still_q : still_q + 8'd1;
	end

	// homing torque ramp with saturation
	always_comb begin
		ramp_sum  = SW'(dac_q) + SW'($signed({1'b0, cfg.dac_step}));
		ramp_fits = (&ramp_sum[SW-1:DAC_BITS-1]) || !(|ramp_sum[SW-1:DAC_BITS-1]);
		if (ramp_fits) begin
			ramp_sat = ramp_sum[DAC_BITS-1:0];
		end else begin
			ramp_sat = ramp_sum[SW-1] ? DAC_MINV : DAC_MAXV;
		end
		settle_start = (cfg.settle_ticks == 16'd0) ? 16'd1 : cfg.settle_ticks;
	end

	// next-state update for one command
	always_comb begin
		clamp_d  = clamp_q;
		mech_d   = mech_q;
		mode_d   = mode_q;
		homing_d = homing_q;
		last_d   = last_q;
		still_d  = still_q;
		dac_d    = dac_q;
		settle_d = settle_q;
		zero_d   = zero_q;
		target_d = target_q;
		acc      = 1'b1;
		homed    = 1'b0;
		unique case (op)
			OP_TICK: begin
				// homing first
				if (homing_q) begin
					if (is_still) begin
						still_d = still_inc;
						if (still_inc >= cfg.still_needed) begin
							homing_d = 1'b0;
							dac_d    = '0;
							mode_d   = MODE_POS;
							zero_d   = raw;
							target_d = '0;
							clamp_d  = CLAMP_CLOSED;
							mech_d   = MECH_READY;
							homed    = 1'b1;
						end
					end else begin
						still_d = 8'd0;
						last_d  = raw;
						if (dac_q < cfg.max_dac) begin
							dac_d = ramp_sat;
						end
					end
				end
				// then the open/close settle countdown
				if (settle_q != 16'd0) begin
					settle_d = settle_q - 16'd1;
					if (settle_q == 16'd1) begin
						if (clamp_d == CLAMP_OPENING) begin
							clamp_d = CLAMP_OPEN;
							mech_d  = MECH_READY;
						end else if (clamp_d == CLAMP_CLOSING) begin
							mode_d   = MODE_POS;
							target_d = raw - zero_d;
							clamp_d  = CLAMP_CLOSED;
							mech_d   = MECH_HOLDING;
						end
					end
				end
			end
			OP_OPEN, OP_CLOSE, OP_HOME: begin
				if (mech_q != MECH_READY) begin
					acc = 1'b0;
				end else begin
					mode_d = MODE_TORQUE;
					dac_d  = cmd_dac;
					if (op == OP_OPEN) begin
						clamp_d  = CLAMP_OPENING;
						mech_d   = MECH_MOVING;
						settle_d = settle_start;
					end else if (op == OP_CLOSE) begin
						clamp_d  = CLAMP_CLOSING;
						mech_d   = MECH_MOVING;
						settle_d = settle_start;
					end else begin
						mech_d   = MECH_HOMING;
						homing_d = 1'b1;
						last_d   = raw;
						still_d  = 8'd0;
					end
				end
			end
			OP_STOP, OP_RESET: begin
				if (homing_q) begin
					homing_d = 1'b0;
					dac_d    = '0;
				end
				mode_d = MODE_STOPPED;
				mech_d = MECH_HOLDING;
				if (op == OP_RESET) begin
					settle_d = 16'd0;
					clamp_d  = CLAMP_UNKNOWN;
					mech_d   = MECH_READY;
				end
			end
			default: begin
				acc = 1'b0;
			end
		endcase
		rel = raw - zero_d;
	end

	// state registers, advanced once per popped beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_q  <= CLAMP_UNKNOWN;
			mech_q   <= MECH_READY;
			mode_q   <= MODE_POS;
			homing_q <= 1'b0;
			last_q   <= '0;
			still_q  <= 8'd0;
			dac_q    <= '0;
			settle_q <= 16'd0;
			zero_q   <= '0;
			target_q <= '0;
		end else if (pop) begin
			clamp_q  <= clamp_d;
			mech_q   <= mech_d;
			mode_q   <= mode_d;
			homing_q <= homing_d;
			last_q   <= last_d;
			still_q  <= still_d;
			dac_q    <= dac_d;
			settle_q <= settle_d;
			zero_q   <= zero_d;
			target_q <= target_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (pop) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			acc_q   <= acc;
			homed_q <= homed;
			rel_q   <= rel;
		end
	end

	assign rsp.valid        = ovalid_q;
	assign rsp.accepted     = acc_q;
	assign rsp.clamp_state  = clamp_q;
	assign rsp.mech_state   = mech_q;
	assign rsp.drive_mode   = mode_q;
	assign rsp.dac_out      = dac_q;
	assign rsp.target_pos   = target_q;
	assign rsp.rel_position = rel_q;
	assign rsp.homed_now    = homed_q;

endmodule

// ===== rtl/gripper_clamp_and_stall_homing.sv =====
// An accepted request beat is written into the queue; when popped, its result is
// registered and the result beat becomes valid.
// Throughput: one beat per cycle; while a result waits on rsp.ready the two-entry
// queue keeps taking request beats until it is full, then req.ready drops.
// Reset (arst_n low, asynchronous): queue emptied, sequencer state cleared,
// configuration registers back to their defaults.
module gripper_clamp_and_stall_homing #(
	parameter int DAC_BITS = 16,
	parameter int POS_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	gcsh_req_if.sink    req,
	gcsh_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	import gcsh_pkg::*;

	localparam int EW = OP_BITS + POS_BITS + DAC_BITS;

	cfg_t          cfg;
	logic          push_valid;
	logic          push_ready;
	logic [EW-1:0] push_data;
	logic          pop_valid;
	logic          pop_ready;
	logic [EW-1:0] pop_data;

	// intake and classification
	gcsh_front #(
		.DAC_BITS(DAC_BITS),
		.POS_BITS(POS_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decoupling queue
	gcsh_queue #(
		.WIDTH(EW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_data   (push_data),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_data  (pop_data)
	);

	// sequencer
	gcsh_back #(
		.DAC_BITS(DAC_BITS),
		.POS_BITS(POS_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.rsp       (rsp)
	);

endmodule

// ===== rtl/gcsh_chk.sv =====
// port-level checker for the gripper sequencer, bound to the top level
// depends on gcsh_pkg and assert_macros.svh
`include "assert_macros.svh"

module gcsh_chk #(
	parameter int DAC_BITS = 16,
	parameter int POS_BITS = 32
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic                       accepted,
	input logic [2:0]                 clamp_state,
	input logic [1:0]                 mech_state,
	input logic [1:0]                 drive_mode,
	input logic signed [DAC_BITS-1:0] dac_out,
	input logic signed [POS_BITS-1:0] target_pos,
	input logic signed [POS_BITS-1:0] rel_position,
	input logic                       homed_now
);
	import gcsh_pkg::*;

	// homing completion leaves the gripper closed, ready, in position mode at zero
	`CHK_IMPLY(a_homed_state, clk, arst_n, rsp_valid && homed_now, clamp_state == CLAMP_CLOSED && mech_state == MECH_READY && drive_mode == MODE_POS && dac_out == '0 && target_pos == '0, "homing completion state wrong")
	// the completing tick's position becomes the new zero
	`CHK_IMPLY(a_homed_zero, clk, arst_n, rsp_valid && homed_now, rel_position == '0, "position not zeroed on homing")
	// homing always drives in torque mode
	`CHK_IMPLY(a_homing_torque, clk, arst_n, rsp_valid && mech_state == MECH_HOMING, drive_mode == MODE_TORQUE, "homing outside torque mode")
	// a stalled result beat holds
	`CHK_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(accepted) && $stable(clamp_state) && $stable(rel_position), "stalled result beat changed")

endmodule

bind gripper_clamp_and_stall_homing gcsh_chk #(
	.DAC_BITS(DAC_BITS),
	.POS_BITS(POS_BITS)
) u_gcsh_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.accepted     (rsp.accepted),
	.clamp_state  (rsp.clamp_state),
	.mech_state   (rsp.mech_state),
	.drive_mode   (rsp.drive_mode),
	.dac_out      (rsp.dac_out),
	.target_pos   (rsp.target_pos),
	.rel_position (rsp.rel_position),
	.homed_now    (rsp.homed_now)
);

// ===== test/tb_gripper_clamp_and_stall_homing.sv =====
// testbench for the gripper clamp and stall homing sequencer: directed and random event beats,
// each result beat checked field by field against an in-bench model of the sequencer
// depends on gcsh_pkg, gcsh_req_if, gcsh_rsp_if and gripper_clamp_and_stall_homing
`timescale 1ns / 1ps

module tb_gripper_clamp_and_stall_homing;
	import gcsh_pkg::*;

	// spare request code with no name in the package
	localparam logic [2:0] REQ_SPARE = 3'd7;

	typedef struct packed {
		logic               accepted;
		logic [2:0]         clamp_state;
		logic [1:0]         mech_state;
		logic [1:0]         drive_mode;
		logic signed [15:0] dac_out;
		logic signed [31:0] target_pos;
		logic signed [31:0] rel_position;
		logic               homed_now;
	} gripper_status_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_wdata;

	gcsh_req_if #(.POS_BITS(32)) req_ch ();
	gcsh_rsp_if #(.DAC_BITS(16), .POS_BITS(32)) rsp_ch ();

	gripper_clamp_and_stall_homing #(
		.DAC_BITS(16),
		.POS_BITS(32)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// settings as the block should hold them
	logic signed [15:0] cfg_open_trq  = -16'sd100;
	logic signed [15:0] cfg_close_trq = 16'sd100;
	logic signed [15:0] cfg_ramp_init = 16'sd10;
	logic signed [15:0] cfg_max_dac   = 16'sd80;
	logic [14:0]        cfg_dac_step  = 15'd10;
	logic [15:0]        cfg_still_thr = 16'd1;
	logic [7:0]         cfg_still_need = 8'd5;
	logic [15:0]        cfg_settle    = 16'd5;

	// sequencer state as the block should hold it
	logic [2:0]         grip_clamp     = CLAMP_UNKNOWN;
	logic [1:0]         grip_mech      = MECH_READY;
	logic [1:0]         grip_mode      = MODE_POS;
	logic               grip_homing    = 1'b0;
	logic signed [31:0] grip_last_pos  = '0;
	logic [7:0]         grip_still_cnt = '0;
	logic signed [15:0] grip_dac       = '0;
	logic [15:0]        grip_settle    = '0;
	logic signed [31:0] grip_zero      = '0;
	logic signed [31:0] grip_target    = '0;

	gripper_status_t    pending_status[$];
	int                 mismatch_count = 0;
	int                 sent_items = 0;
	logic signed [31:0] cur_pos = '0;

	// idle stretches for both channels
	int send_run_left = 0;
	bit send_calm = 1'b0;
	int recv_run_left = 0;
	bit recv_calm = 1'b0;
	int rsp_hold = 0;

	// one event applied to the sequencer state, status taken after the update
	function automatic gripper_status_t step_gripper(input logic [2:0] kind,
			input logic signed [31:0] pos, input logic signed [15:0] torque);
		gripper_status_t s;
		longint moved;
		longint ramp;
		s = '0;
		s.accepted = 1'b1;
		case (kind)
			OP_TICK: begin
				// stall detection runs before the settle countdown
				if (grip_homing) begin
					moved = longint'(pos) - longint'(grip_last_pos);
					if (moved < 0)
						moved = -moved;
					if (moved < longint'(cfg_still_thr)) begin
						if (grip_still_cnt != 8'hff)
							grip_still_cnt++;
						if (grip_still_cnt >= cfg_still_need) begin
							grip_homing = 1'b0;
							grip_dac = '0;
							grip_mode = MODE_POS;
							grip_zero = pos;
							grip_target = '0;
							grip_clamp = CLAMP_CLOSED;
							grip_mech = MECH_READY;
							s.homed_now = 1'b1;
						end
					end else begin
						grip_still_cnt = '0;
						grip_last_pos = pos;
						// ramp saturates at the top of the dac range
						if (grip_dac < cfg_max_dac) begin
							ramp = longint'(grip_dac) + longint'(cfg_dac_step);
							grip_dac = (ramp > 32767) ? 16'sh7fff : 16'(ramp);
						end
					end
				end
				if (grip_settle != '0) begin
					grip_settle--;
					if (grip_settle == '0) begin
						if (grip_clamp == CLAMP_OPENING) begin
							grip_clamp = CLAMP_OPEN;
							grip_mech = MECH_READY;
						end else if (grip_clamp == CLAMP_CLOSING) begin
							grip_mode = MODE_POS;
							grip_target = pos - grip_zero;
							grip_clamp = CLAMP_CLOSED;
							grip_mech = MECH_HOLDING;
						end
					end
				end
			end
			OP_OPEN, OP_CLOSE, OP_HOME: begin
				if (grip_mech != MECH_READY) begin
					s.accepted = 1'b0;
				end else begin
					grip_mode = MODE_TORQUE;
					if (kind == OP_HOME) begin
						grip_dac = cfg_ramp_init;
						grip_mech = MECH_HOMING;
						grip_homing = 1'b1;
						grip_last_pos = pos;
						grip_still_cnt = '0;
					end else begin
						grip_mech = MECH_MOVING;
						grip_settle = (cfg_settle == '0) ? 16'd1 : cfg_settle;
						if (kind == OP_OPEN) begin
							grip_dac = cfg_open_trq;
							grip_clamp = CLAMP_OPENING;
						end else begin
							grip_dac = (torque > 0) ? torque : cfg_close_trq;
							grip_clamp = CLAMP_CLOSING;
						end
					end
				end
			end
			OP_STOP, OP_RESET: begin
				if (grip_homing) begin
					grip_homing = 1'b0;
					grip_dac = '0;
				end
				grip_mode = MODE_STOPPED;
				grip_mech = MECH_HOLDING;
				// reset also drops a pending completion
				if (kind == OP_RESET) begin
					grip_settle = '0;
					grip_clamp = CLAMP_UNKNOWN;
					grip_mech = MECH_READY;
				end
			end
			default: s.accepted = 1'b0;
		endcase
		s.clamp_state = grip_clamp;
		s.mech_state = grip_mech;
		s.drive_mode = grip_mode;
		s.dac_out = grip_dac;
		s.target_pos = grip_target;
		s.rel_position = pos - grip_zero;
		return s;
	endfunction

	// wait before the next beat, with stretches of no waiting
	function automatic int draw_wait(ref int run_left, ref bit run_calm);
		if (run_left == 0) begin
			run_left = $urandom_range(8, 60);
			run_calm = ($urandom_range(0, 3) == 0);
		end
		run_left--;
		return run_calm ? 0 : $urandom_range(0, 19);
	endfunction

	// drive one event beat and record the status it should produce
	task automatic send_event(input logic [2:0] kind, input logic signed [31:0] pos,
			input logic signed [15:0] torque);
		int gap;
		gripper_status_t s;
		gap = draw_wait(send_run_left, send_calm);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.raw_position <= pos;
		req_ch.close_torque <= torque;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		s = step_gripper(kind, pos, torque);
		pending_status.push_back(s);
		sent_items++;
		@(negedge clk);
	endtask

	// hold off until every result beat is in, then let the pipeline empty
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_status.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		case (index)
			CFG_OPEN_TRQ:   cfg_open_trq = data;
			CFG_CLOSE_TRQ:  cfg_close_trq = data;
			CFG_RAMP_INIT:  cfg_ramp_init = data;
			CFG_MAX_DAC:    cfg_max_dac = data;
			CFG_DAC_STEP:   cfg_dac_step = data[14:0];
			CFG_STILL_THR:  cfg_still_thr = data;
			CFG_STILL_NEED: cfg_still_need = data[7:0];
			CFG_SETTLE:     cfg_settle = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_settings(input logic [15:0] od, cd, idac, mdac, step, thr, need,
			settle);
		write_reg(CFG_OPEN_TRQ, od);
		write_reg(CFG_CLOSE_TRQ, cd);
		write_reg(CFG_RAMP_INIT, idac);
		write_reg(CFG_MAX_DAC, mdac);
		write_reg(CFG_DAC_STEP, step);
		write_reg(CFG_STILL_THR, thr);
		write_reg(CFG_STILL_NEED, need);
		write_reg(CFG_SETTLE, settle);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// ticks that either move past the threshold or sit near the last moving position
	task automatic send_ticks(input int count, input bit hold_still);
		longint off;
		int k;
		for (k = 0; k < count; k++) begin
			if (hold_still) begin
				off = (cfg_still_thr == '0) ? 0 : $urandom_range(0, cfg_still_thr - 1);
				if ($urandom_range(0, 1))
					off = -off;
				cur_pos = 32'(longint'(grip_last_pos) + off);
			end else begin
				off = longint'(cfg_still_thr) + $urandom_range(0, 5000);
				if ($urandom_range(0, 1))
					off = -off;
				cur_pos = 32'(longint'(cur_pos) + off);
			end
			send_event(OP_TICK, cur_pos, 16'($urandom));
		end
	endtask

	// home, a few moving ticks, then enough still ticks to finish, sometimes broken
	task automatic run_homing_seq();
		int moves;
		int stills;
		if (grip_mech != MECH_READY && $urandom_range(0, 3) != 0)
			send_event(OP_RESET, $urandom, 16'($urandom));
		cur_pos = $urandom;
		send_event(OP_HOME, cur_pos, 16'($urandom));
		moves = $urandom_range(0, 4);
		send_ticks(moves, 1'b0);
		if ($urandom_range(0, 7) == 0)
			send_event($urandom_range(0, 1) ? OP_STOP : OP_RESET, cur_pos, 16'($urandom));
		if (cfg_still_thr == '0)
			stills = $urandom_range(1, 6);
		else
			stills = int'(cfg_still_need) + $urandom_range(0, 2);
		send_ticks(stills, 1'b1);
	endtask

	// open or close, then ticks around the settle count, sometimes interrupted
	task automatic run_grip_seq(input bit closing);
		int span;
		int ticks;
		int lead;
		logic signed [15:0] torque;
		if (grip_mech != MECH_READY && $urandom_range(0, 3) != 0)
			send_event(OP_RESET, $urandom, 16'($urandom));
		case ($urandom_range(0, 3))
			0: torque = '0;
			1: torque = -16'sd1 - 16'($urandom_range(0, 32767));
			2: torque = 16'sh7fff;
			default: torque = 16'($urandom_range(1, 32767));
		endcase
		send_event(closing ? OP_CLOSE : OP_OPEN, cur_pos, torque);
		span = (cfg_settle == '0) ? 1 : int'(cfg_settle);
		ticks = (span > 64) ? $urandom_range(2, 8) : span - 1 + $urandom_range(0, 3);
		lead = $urandom_range(0, ticks);
		send_ticks(lead, 1'b0);
		if ($urandom_range(0, 5) == 0)
			send_event($urandom_range(0, 1) ? OP_STOP : OP_RESET, cur_pos, 16'($urandom));
		send_ticks(ticks - lead, 1'b0);
	endtask

	// reset values, unused codes, refusals and a completion that survives a stop
	task automatic test_reset_values();
		send_event(OP_TICK, 32'sh7fff_ffff, 16'sh8000);
		send_event(OP_TICK, 32'sh8000_0000, 16'sh7fff);
		send_event(OP_NONE, 32'sh1234_5678, 16'sd1);
		send_event(REQ_SPARE, 32'shedcb_a987, -16'sd1);
		send_event(OP_OPEN, 32'sd500, 16'sd0);
		send_event(OP_CLOSE, 32'sd500, 16'sd300);
		send_event(OP_HOME, 32'sd500, 16'sd0);
		send_event(OP_STOP, 32'sd500, 16'sd0);
		repeat (5) send_event(OP_TICK, 32'sd510, 16'sd0);
	endtask

	// extreme settings: zero settle, torque fallback, saturating ramp, stop while homing
	task automatic test_extreme_settings();
		wait_for_results();
		apply_settings(16'h8000, 16'h7fff, 16'd32000, 16'h7fff, 16'h7fff, 16'hffff, 16'd0,
			16'd0);
		send_event(OP_RESET, 32'sd0, 16'sd0);
		send_event(OP_CLOSE, 32'sd250, 16'sh8000);
		send_event(OP_TICK, 32'sd1000, 16'sd0);
		send_event(OP_RESET, 32'sd1000, 16'sd0);
		send_event(OP_HOME, 32'sd0, 16'sd0);
		send_event(OP_TICK, 32'sd70000, 16'sd0);
		send_event(OP_TICK, 32'sd70010, 16'sd0);
		send_event(OP_HOME, 32'sd5, 16'sd0);
		send_event(OP_STOP, 32'sd5, 16'sd0);
		send_event(OP_OPEN, 32'sd5, 16'sd0);
		send_event(OP_RESET, 32'sd5, 16'sd0);
	endtask

	// random sequences under one group of settings
	task automatic test_mixed_traffic(input logic [15:0] od, cd, idac, mdac, step, thr,
			need, settle, input int budget);
		int stop_at;
		int pick;
		wait_for_results();
		apply_settings(od, cd, idac, mdac, step, thr, need, settle);
		stop_at = sent_items + budget;
		run_homing_seq();
		while (sent_items < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				run_homing_seq();
			else if (pick < 45)
				run_grip_seq(1'b0);
			else if (pick < 65)
				run_grip_seq(1'b1);
			else if (pick < 72)
				send_event(OP_STOP, $urandom, 16'($urandom));
			else if (pick < 80)
				send_event(OP_RESET, $urandom, 16'($urandom));
			else if (pick < 97)
				repeat ($urandom_range(1, 4))
					send_event(3'($urandom_range(0, 7)), $urandom, 16'($urandom));
			else
				wait_for_results();
		end
	endtask

	// result side stalls between beats
	initial begin : result_ready
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold--;
			end else
				rsp_ch.ready <= 1'b1;
		end
	end

	// compare each result beat with the oldest expected status
	always @(posedge clk) begin : status_check
		gripper_status_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			rsp_hold = draw_wait(recv_run_left, recv_calm);
			if (pending_status.size() == 0) begin
				$error("result beat with no command waiting for it");
				mismatch_count++;
			end else begin
				want = pending_status.pop_front();
				if (rsp_ch.accepted !== want.accepted) begin
					$error("accepted: expected %0d, actual %0d", want.accepted, rsp_ch.accepted);
					mismatch_count++;
				end
				if (rsp_ch.clamp_state !== want.clamp_state) begin
					$error("clamp_state: expected %0d, actual %0d", want.clamp_state,
						rsp_ch.clamp_state);
					mismatch_count++;
				end
				if (rsp_ch.mech_state !== want.mech_state) begin
					$error("mech_state: expected %0d, actual %0d", want.mech_state,
						rsp_ch.mech_state);
					mismatch_count++;
				end
				if (rsp_ch.drive_mode !== want.drive_mode) begin
					$error("drive_mode: expected %0d, actual %0d", want.drive_mode,
						rsp_ch.drive_mode);
					mismatch_count++;
				end
				if (rsp_ch.dac_out !== want.dac_out) begin
					$error("dac_out: expected %0d, actual %0d", want.dac_out, rsp_ch.dac_out);
					mismatch_count++;
				end
				if (rsp_ch.target_pos !== want.target_pos) begin
					$error("target_pos: expected %0d, actual %0d", want.target_pos,
						rsp_ch.target_pos);
					mismatch_count++;
				end
				if (rsp_ch.rel_position !== want.rel_position) begin
					$error("rel_position: expected %0d, actual %0d", want.rel_position,
						rsp_ch.rel_position);
					mismatch_count++;
				end
				if (rsp_ch.homed_now !== want.homed_now) begin
					$error("homed_now: expected %0d, actual %0d", want.homed_now,
						rsp_ch.homed_now);
					mismatch_count++;
				end
			end
		end
	end

	// test sequence
	initial begin : run_tests
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = '0;
		req_ch.raw_position = '0;
		req_ch.close_torque = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_values();
		test_extreme_settings();
		test_mixed_traffic(16'($urandom), 16'($urandom), 16'($urandom_range(0, 5000)),
			16'($urandom_range(0, 20000)), 16'($urandom_range(0, 4000)),
			16'($urandom_range(1, 64)), 16'($urandom_range(0, 6)),
			16'($urandom_range(0, 8)), 250);
		// opposite extremes: step masked to zero, nothing ever still, nothing settles
		test_mixed_traffic(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd0,
			16'd255, 16'hffff, 100);
		// longest still run, init of -50 below a positive ceiling
		test_mixed_traffic(16'($urandom), 16'($urandom), 16'hffce, 16'd400, 16'd7, 16'd4,
			16'd255, 16'd40, 250);
		repeat (3)
			test_mixed_traffic(16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom_range(0, 20000)), 16'($urandom_range(0, 4000)),
				16'($urandom_range(1, 64)), 16'($urandom_range(0, 6)),
				16'($urandom_range(0, 8)), 217);

		wait_for_results();
		if (mismatch_count == 0 && pending_status.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// run limit
	initial begin : watchdog
		#(10_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
